>>> sv/bdeq_pkg.sv
// ---------------------------------------------------------------------------
// bdeq_pkg: shared types and constants of the button debouncer
// Operation codes, register indexes, reset values and the per-lane structs.
// ---------------------------------------------------------------------------
package bdeq_pkg;

	// defaults of the top-level parameters
	localparam int BUTTON_COUNT_DEF = 3;
	localparam int QUEUE_DEPTH_DEF  = 8;

	// operation codes carried in each input transfer
	typedef enum logic [1:0] {
		OP_POLL  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_START = 2'd3
	} op_t;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REST_WIN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_LIM  = 2'd2;

	// register reset values
	localparam logic [15:0] DEBOUNCE_RST  = 16'd20;
	localparam logic [15:0] REST_WIN_RST  = 16'd1000;
	localparam logic [7:0]  NOISE_LIM_RST = 8'd3;

	// levels and limits
	localparam logic       REST_LEVEL   = 1'b1;
	localparam logic       ACTIVE_LEVEL = 1'b0;
	localparam logic [7:0] HITS_MAX     = 8'hFF;

	typedef struct packed {
		logic        poll;    // poll while running
		logic        clear;   // clear counters (clear or start)
		logic        start;   // sample levels, restart timers
		logic        level;   // raw level of this lane's button
		logic [31:0] now_ms;
	} lane_cmd_t;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [15:0] rest_window_ms;
		logic [7:0]  rest_noise_limit;
	} lane_cfg_t;

	// lane state after the current transfer
	typedef struct packed {
		logic        stable;
		logic        noisy;
		logic        push;    // new debounced edge
		logic        rising;
		logic [31:0] press;
		logic [31:0] bounce;
		logic [31:0] noise;
	} lane_stat_t;

	typedef struct packed {
		logic pop;
		logic clear;
	} q_ctrl_t;

endpackage

>>> sv/bdeq_lane.sv
// ---------------------------------------------------------------------------
// bdeq_lane: debouncer for one button
// Holds the button's levels, timer, counters and rest-noise window, and
// reports its state after each transfer together with any new edge.
// ---------------------------------------------------------------------------
module bdeq_lane import bdeq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lane_cmd_t  cmd,
	input  lane_cfg_t  cfg,
	output lane_stat_t stat
);

	logic        stable_q, last_q, noisy_q;
	logic [31:0] change_q, press_q, bounce_q, noise_q, win_start_q;
	logic [7:0]  hits_q;

	logic        stable_d, last_d, noisy_d, push;
	logic [31:0] change_d, press_d, bounce_d, noise_d, win_start_d;
	logic [7:0]  hits_d;

	// next state
	always_comb begin
		logic       win_done;
		logic [7:0] hits_base;
		stable_d    = stable_q;
		last_d      = last_q;
		noisy_d     = noisy_q;
		change_d    = change_q;
		press_d     = press_q;
		bounce_d    = bounce_q;
		noise_d     = noise_q;
		win_start_d = win_start_q;
		hits_d      = hits_q;
		push        = 1'b0;
		win_done    = (cmd.now_ms - win_start_q) >= {16'd0, cfg.rest_window_ms};
		hits_base   = win_done ? 8'd0 : hits_q;
		if (cmd.clear) begin
			if (cmd.start) begin
				stable_d = cmd.level;
				last_d   = cmd.level;
				change_d = cmd.now_ms;
			end
			press_d     = '0;
			bounce_d    = '0;
			noise_d     = '0;
			win_start_d = cmd.now_ms;
			hits_d      = '0;
			noisy_d     = 1'b0;
		end else if (cmd.poll) begin
			if (cmd.level != last_q) begin
				// raw change: restart timer
				last_d   = cmd.level;
				change_d = cmd.now_ms;
				if (cmd.level == stable_q)
					bounce_d = bounce_q + 32'd1;
				if (stable_q == REST_LEVEL) begin
					if (win_done)
						win_start_d = cmd.now_ms;
					hits_d  = (hits_base == HITS_MAX) ? HITS_MAX : hits_base + 8'd1;
					noise_d = noise_q + 32'd1;
					if (hits_d >= cfg.rest_noise_limit)
						noisy_d = 1'b1;
				end
			end else if (cmd.level != stable_q &&
			             (cmd.now_ms - change_q) >= {16'd0, cfg.debounce_ms}) begin
				// level held long enough: new stable level
				stable_d = cmd.level;
				push     = 1'b1;
				if (cmd.level == ACTIVE_LEVEL)
					press_d = press_q + 32'd1;
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q    <= REST_LEVEL;
			last_q      <= REST_LEVEL;
			noisy_q     <= 1'b0;
			change_q    <= '0;
			press_q     <= '0;
			bounce_q    <= '0;
			noise_q     <= '0;
			win_start_q <= '0;
			hits_q      <= '0;
		end else begin
			stable_q    <= stable_d;
			last_q      <= last_d;
			noisy_q     <= noisy_d;
			change_q    <= change_d;
			press_q     <= press_d;
			bounce_q    <= bounce_d;
			noise_q     <= noise_d;
			win_start_q <= win_start_d;
			hits_q      <= hits_d;
		end
	end

	assign stat.stable = stable_d;
	assign stat.noisy  = noisy_d;
	assign stat.push   = push;
	assign stat.rising = cmd.level;
	assign stat.press  = press_d;
	assign stat.bounce = bounce_d;
	assign stat.noise  = noise_d;

endmodule

>>> sv/bdeq_queue.sv
// ---------------------------------------------------------------------------
// bdeq_queue: drop-oldest edge queue
// Merges the edges of all lanes in button order, drops the oldest edge when
// full and counts the drops; serves pops from the head.
// ---------------------------------------------------------------------------
module bdeq_queue import bdeq_pkg::*; #(
	parameter  int BUTTON_COUNT = BUTTON_COUNT_DEF,
	parameter  int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	localparam int BTN_W  = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1,
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  q_ctrl_t                 ctrl,
	input  logic [BUTTON_COUNT-1:0] push,
	input  logic [BUTTON_COUNT-1:0] push_rising,
	output logic                    edge_valid,
	output logic [BTN_W-1:0]        edge_button,
	output logic                    edge_rising,
	output logic [FILL_W-1:0]       fill,
	output logic [FILL_W-1:0]       fill_next,
	output logic [31:0]             dropped_next
);

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int ENT_W  = BTN_W + 1;
	localparam int DROP_W = $clog2(BUTTON_COUNT + 1);

	logic [ENT_W-1:0]  store_q [QUEUE_DEPTH];
	logic [ENT_W-1:0]  store_d [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wp_q, rp_q, wp_d, rp_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [31:0]       dropped_q, dropped_d;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// pop, clear or merge of the lanes' edges
	always_comb begin
		logic [DROP_W-1:0] drops;
		store_d     = store_q;
		wp_d        = wp_q;
		rp_d        = rp_q;
		fill_d      = fill_q;
		drops       = '0;
		edge_valid  = 1'b0;
		edge_button = '0;
		edge_rising = 1'b0;
		if (ctrl.clear) begin
			wp_d   = '0;
			rp_d   = '0;
			fill_d = '0;
		end else if (ctrl.pop) begin
			if (fill_q != '0) begin
				edge_valid               = 1'b1;
				{edge_button, edge_rising} = store_q[rp_q];
				rp_d                     = ptr_inc(rp_q);
				fill_d                   = fill_q - 1'b1;
			end
		end else begin
			for (int b = 0; b < BUTTON_COUNT; b++) begin
				if (push[b]) begin
					if (fill_d == FILL_W'(QUEUE_DEPTH)) begin
						rp_d   = ptr_inc(rp_d);
						fill_d = fill_d - 1'b1;
						drops  = drops + 1'b1;
					end
					store_d[wp_d] = {BTN_W'(b), push_rising[b]};
					wp_d          = ptr_inc(wp_d);
					fill_d        = fill_d + 1'b1;
				end
			end
		end
		dropped_d = ctrl.clear ? '0 : dropped_q + 32'(drops);
	end

	// entry storage, no reset
	always_ff @(posedge clk) begin
		store_q <= store_d;
	end

	// pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			fill_q    <= '0;
			dropped_q <= '0;
		end else begin
			wp_q      <= wp_d;
			rp_q      <= rp_d;
			fill_q    <= fill_d;
			dropped_q <= dropped_d;
		end
	end

	assign fill         = fill_q;
	assign fill_next    = fill_d;
	assign dropped_next = dropped_d;

endmodule

>>> sv/button_debounce_edge_queue_core.sv
// ---------------------------------------------------------------------------
// button_debounce_edge_queue_core: debouncer with edge queue
//
// Input stream s_*: one transfer per operation (poll, pop edge, clear,
// start). Output stream m_*: exactly one result transfer per input
// transfer, in order, giving the state after that operation.
// One lane per button debounces in parallel; the queue merges the lanes'
// edges in button order into a drop-oldest FIFO.
// The result is registered in the output register, or in the skid entry
// while a result waits. Throughput: one item per cycle while s_tready is
// high; all lane updates and the edge merge are combinational.
// A two-entry output buffer (register plus skid) lets one more item be
// taken while a result waits; with both full s_tready drops until the
// receiver takes a result.
// Reset (arst_n low): levels high, counters, queue and marks cleared,
// polling disabled until a start operation; registers back to defaults.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered in cfg_q.
// ---------------------------------------------------------------------------
module button_debounce_edge_queue_core import bdeq_pkg::*; #(
	parameter  int BUTTON_COUNT = BUTTON_COUNT_DEF,
	parameter  int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	localparam int BTN_W   = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1,
	localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1),
	localparam int IN_BITS = 2 + BUTTON_COUNT + 32 + BTN_W,
	localparam int IN_W    = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = 2 * BUTTON_COUNT + BTN_W + FILL_W + 4 * 32 + 3,
	localparam int OUT_W   = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// operation, raw_levels, now_ms, query_button
	input  logic [IN_W-1:0]       s_tdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// stable_levels, noisy_flags, edge_valid, edge_button, edge_rising,
	// queue_fill, overflow_count, press_total, bounce_total,
	// rest_noise_total, started
	output logic [OUT_W-1:0]      m_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	op_t                     op;
	logic [BUTTON_COUNT-1:0] raw;
	logic [31:0]             now_ms;
	logic [BTN_W-1:0]        query;
	logic                    acc;

	lane_cfg_t  cfg_q;
	lane_cmd_t  cmd [BUTTON_COUNT];
	lane_stat_t stat [BUTTON_COUNT];
	logic       running_q, running_d;

	logic [BUTTON_COUNT-1:0] push, push_rising, stable_vec, noisy_vec, stable_now;
	q_ctrl_t                 qctrl;
	logic                    edge_valid, edge_rising;
	logic [BTN_W-1:0]        edge_button;
	logic [FILL_W-1:0]       fill, fill_next;
	logic [31:0]             dropped_next;
	logic [31:0]             press_sel, bounce_sel, noise_sel;

	logic [OUT_W-1:0] res_d, out_q, skid_q;
	logic             out_valid_q, skid_valid_q;

	// input fields
	assign op     = op_t'(s_tdata[1:0]);
	assign raw    = s_tdata[2 +: BUTTON_COUNT];
	assign now_ms = s_tdata[2 + BUTTON_COUNT +: 32];
	assign query  = s_tdata[2 + BUTTON_COUNT + 32 +: BTN_W];
	assign acc    = s_tvalid && s_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms      <= DEBOUNCE_RST;
			cfg_q.rest_window_ms   <= REST_WIN_RST;
			cfg_q.rest_noise_limit <= NOISE_LIM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:  cfg_q.debounce_ms      <= cfg_data;
				REG_REST_WIN:  cfg_q.rest_window_ms   <= cfg_data;
				REG_NOISE_LIM: cfg_q.rest_noise_limit <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// running flag
	assign running_d = (acc && op == OP_START) ? 1'b1 : running_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			running_q <= 1'b0;
		else
			running_q <= running_d;
	end

	// lanes
	for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_lane
		assign cmd[b].poll   = acc && op == OP_POLL && running_q;
		assign cmd[b].clear  = acc && (op == OP_CLEAR || op == OP_START);
		assign cmd[b].start  = acc && op == OP_START;
		assign cmd[b].level  = raw[b];
		assign cmd[b].now_ms = now_ms;

		bdeq_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd[b]),
			.cfg    (cfg_q),
			.stat   (stat[b])
		);

		assign push[b]        = stat[b].push;
		assign push_rising[b] = stat[b].rising;
		assign stable_vec[b]  = stat[b].stable;
		assign noisy_vec[b]   = stat[b].noisy;
		assign stable_now[b]  = u_lane.stable_q;
	end

	// edge queue
	assign qctrl.pop   = acc && op == OP_POP;
	assign qctrl.clear = acc && (op == OP_CLEAR || op == OP_START);

	bdeq_queue #(
		.BUTTON_COUNT (BUTTON_COUNT),
		.QUEUE_DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (qctrl),
		.push         (push),
		.push_rising  (push_rising),
		.edge_valid   (edge_valid),
		.edge_button  (edge_button),
		.edge_rising  (edge_rising),
		.fill         (fill),
		.fill_next    (fill_next),
		.dropped_next (dropped_next)
	);

	// queried counters, zero for a button out of range
	always_comb begin
		press_sel  = '0;
		bounce_sel = '0;
		noise_sel  = '0;
		for (int b = 0; b < BUTTON_COUNT; b++) begin
			if (query == BTN_W'(b)) begin
				press_sel  = stat[b].press;
				bounce_sel = stat[b].bounce;
				noise_sel  = stat[b].noise;
			end
		end
	end

	assign res_d = OUT_W'({running_d, noise_sel, bounce_sel, press_sel, dropped_next,
	                       fill_next, edge_rising, edge_button, edge_valid,
	                       noisy_vec, stable_vec});

	// output register with skid entry
	assign s_tready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q  <= skid_valid_q || acc;
			skid_valid_q <= 1'b0;
		end else if (acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready)
			out_q <= skid_valid_q ? skid_q : res_d;
		else if (acc)
			skid_q <= res_d;
	end

	assign m_tdata  = out_q;
	assign m_tvalid = out_valid_q;

	// the skid entry is only ever filled behind a waiting result
	a_skid_behind: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result with the output register empty");

	// a pop of a non-empty queue yields an edge and one fewer entry
	a_pop_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == OP_POP && fill != '0) |-> (edge_valid && fill_next == fill - 1'b1))
		else $error("pop of a non-empty queue gave no edge");

	// polls before start leave the debounced levels untouched
	a_idle_poll: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == OP_POLL && !running_q) |=> (stable_now == $past(stable_now)))
		else $error("poll before start changed a stable level");

	// the queue never holds more than its depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_next <= FILL_W'(QUEUE_DEPTH))
		else $error("queue fill above depth");

endmodule
